>>> design/scfla_pkg.sv
// Package for the size class free list allocator.
// Holds default geometry, status, register and operation codes and the command and status types. No dependencies.
package scfla_pkg;
   localparam int POOL_BYTES_DEF    = 65536;
   localparam int GRANULE_BYTES_DEF = 4;
   localparam int NUM_CLASSES_DEF   = 65;

   localparam logic [1:0] STATUS_POOL    = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_OOM     = 2'd2;

   localparam logic REG_MAX_CLASS = 1'b0;
   localparam logic REG_MIN_BLOCK = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic load;
      logic read_link;
      logic commit;
   } scfla_cmd_type;

   typedef struct packed {
      logic pooled;
      logic is_free;
   } scfla_stat_type;
endpackage

>>> design/size_class_free_list_allocator_unit.sv
// Top level of the size class free list allocator.
// Depends on scfla_pkg, scfla_ctrl and scfla_dpath.
//
// Usage: raise start with req_operation (0 allocate, 1 free), req_request_bytes
// and req_block_address; the word is taken at an edge where start is high and
// busy is low. Busy stays high while the word is worked (ST_LINK, ST_DONE),
// and no new word is taken until it falls. rsp_valid is registered from the
// commit and marks the result on the rsp_ ports for exactly one cycle. The
// steps are the class head read, the link store read and the commit of heads
// and counters, done in sequence.
// Registers max_class_bytes (index 0) and min_block_bytes (index 1) are written
// over the csr_ channel, always ready; write only while idle.
// Reset is synchronous: all lists empty, counters and bump pointer zero,
// registers to 256 and 8. The link store needs no clearing.
// The receiver cannot stall: results are never held.
module size_class_free_list_allocator_unit #(
   parameter int POOL_BYTES    = scfla_pkg::POOL_BYTES_DEF,
   parameter int GRANULE_BYTES = scfla_pkg::GRANULE_BYTES_DEF,
   parameter int NUM_CLASSES   = scfla_pkg::NUM_CLASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_request_bytes,
   input  logic [15:0] req_block_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_granted_address,
   output logic [1:0]  rsp_status,
   output logic        rsp_from_free_list,
   output logic [16:0] rsp_pool_bytes_in_use,
   output logic [31:0] rsp_outside_bytes_in_use,
   output logic [31:0] rsp_live_items
);
   import scfla_pkg::*;

   scfla_cmd_type  cmd;
   scfla_stat_type stat;

   assign csr_ready = 1'b1;

   scfla_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   scfla_dpath #(
      .POOL_BYTES(POOL_BYTES), .GRANULE_BYTES(GRANULE_BYTES),
      .NUM_CLASSES(NUM_CLASSES)
   ) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_operation(req_operation), .req_request_bytes(req_request_bytes),
      .req_block_address(req_block_address),
      .cfg_we(csr_valid & csr_ready), .cfg_idx(csr_index), .cfg_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_granted_address(rsp_granted_address),
      .rsp_status(rsp_status), .rsp_from_free_list(rsp_from_free_list),
      .rsp_pool_bytes_in_use(rsp_pool_bytes_in_use),
      .rsp_outside_bytes_in_use(rsp_outside_bytes_in_use),
      .rsp_live_items(rsp_live_items)
   );
endmodule

>>> design/scfla_ctrl.sv
// Controller for the allocator: sequences load, link read and commit.
// Depends on scfla_pkg.
module scfla_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  scfla_pkg::scfla_stat_type stat,
   output scfla_pkg::scfla_cmd_type  cmd
);
   import scfla_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LINK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.read_link = stat.pooled && !stat.is_free;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

>>> design/scfla_dpath.sv
// Datapath for the allocator: size rounding, class heads, link store, counters.
// Depends on scfla_pkg.
module scfla_dpath #(
   parameter int POOL_BYTES    = scfla_pkg::POOL_BYTES_DEF,
   parameter int GRANULE_BYTES = scfla_pkg::GRANULE_BYTES_DEF,
   parameter int NUM_CLASSES   = scfla_pkg::NUM_CLASSES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scfla_pkg::scfla_cmd_type  cmd,
   output scfla_pkg::scfla_stat_type stat,
   input  logic                      req_operation,
   input  logic [31:0]               req_request_bytes,
   input  logic [15:0]               req_block_address,
   input  logic                      cfg_we,
   input  logic                      cfg_idx,
   input  logic [8:0]                cfg_data,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_granted_address,
   output logic [1:0]                rsp_status,
   output logic                      rsp_from_free_list,
   output logic [16:0]               rsp_pool_bytes_in_use,
   output logic [31:0]               rsp_outside_bytes_in_use,
   output logic [31:0]               rsp_live_items
);
   import scfla_pkg::*;

   localparam int GSH    = $clog2(GRANULE_BYTES);
   localparam int DEPTH  = POOL_BYTES / GRANULE_BYTES;
   localparam int LW     = $clog2(DEPTH) + 1;
   localparam int GW     = $clog2(DEPTH);
   localparam int CW     = $clog2(NUM_CLASSES);
   localparam int PW     = $clog2(POOL_BYTES) + 1;
   localparam logic [PW:0] POOL_LIM = (PW+1)'(POOL_BYTES);

   logic [8:0]  max_ff, min_ff;
   logic        op_ff, pooled_ff;
   logic [32:0] size_ff;
   logic [CW-1:0] cls_ff;
   logic [GW-1:0] fgi_ff;
   logic        fin_ff;
   logic [LW-1:0] head_ff;
   logic [LW-1:0] heads_ff [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] hv_ff;
   logic [LW-1:0] links [DEPTH];
   logic [LW-1:0] link_rd_ff;
   logic [PW:0]  bump_ff;
   logic [16:0]  pool_ff;
   logic [31:0]  out_ff, items_ff;

   // size rounding on the request
   logic [32:0] rnd, size_in;
   logic [32:0] cls_w;
   logic        pooled_in;
   logic [15:0] agi;
   always_comb begin
      rnd = ((33'(req_request_bytes) + 33'(GRANULE_BYTES - 1)) >> GSH) << GSH;
      size_in = (rnd < 33'(min_ff)) ? 33'(min_ff) : rnd;
      cls_w = size_in >> GSH;
      pooled_in = (size_in <= 33'(max_ff)) && (cls_w < 33'(NUM_CLASSES));
      agi = req_block_address >> GSH;
   end

   assign stat.pooled  = pooled_ff;
   assign stat.is_free = op_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         size_ff   <= size_in;
         pooled_ff <= pooled_in;
         cls_ff    <= cls_w[CW-1:0];
         fgi_ff    <= agi[GW-1:0];
         fin_ff    <= (32'(agi) < 32'(DEPTH));
         head_ff   <= hv_ff[cls_w[CW-1:0]] ? heads_ff[cls_w[CW-1:0]] : '0;
      end
   end

   // link store
   logic [GW-1:0] hgi;
   logic          hok;
   assign hgi = GW'(head_ff - LW'(1));
   assign hok = (head_ff != '0) && (32'(head_ff - LW'(1)) < 32'(DEPTH));
   always_ff @(posedge clock) begin
      if (cmd.read_link) link_rd_ff <= links[hgi];
      if (cmd.commit && pooled_ff && op_ff && fin_ff) links[fgi_ff] <= head_ff;
   end

   // commit
   logic [32:0]   bsum;
   logic [15:0]   grant_in;
   logic [1:0]    status_in;
   logic          reuse_in;
   logic [16:0]   pool_in;
   logic [31:0]   out_in, items_in;
   logic [PW:0]   bump_in;
   logic          head_we;
   logic [LW-1:0] head_wd;
   assign bsum = 33'(bump_ff) + size_ff;
   always_comb begin
      grant_in  = '0;
      status_in = STATUS_POOL;
      reuse_in  = 1'b0;
      pool_in   = pool_ff;
      out_in    = out_ff;
      items_in  = items_ff;
      bump_in   = bump_ff;
      head_we   = 1'b0;
      head_wd   = '0;
      if (!pooled_ff) begin
         status_in = STATUS_OUTSIDE;
         if (op_ff == OP_FREE) begin
            out_in   = out_ff - size_ff[31:0];
            items_in = items_ff - 32'd1;
         end else begin
            out_in   = out_ff + size_ff[31:0];
            items_in = items_ff + 32'd1;
         end
      end else if (op_ff == OP_FREE) begin
         items_in = items_ff - 32'd1;
         pool_in  = pool_ff - size_ff[16:0];
         if (fin_ff) begin
            head_we = 1'b1;
            head_wd = LW'(fgi_ff) + LW'(1);
         end
      end else if (hok) begin
         head_we  = 1'b1;
         head_wd  = link_rd_ff;
         grant_in = 16'(32'(hgi) << GSH);
         reuse_in = 1'b1;
         items_in = items_ff + 32'd1;
         pool_in  = pool_ff + size_ff[16:0];
      end else if (bsum <= 33'(POOL_LIM)) begin
         grant_in = 16'(bump_ff);
         bump_in  = bsum[PW:0];
         items_in = items_ff + 32'd1;
         pool_in  = pool_ff + size_ff[16:0];
      end else begin
         status_in = STATUS_OOM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 9'd256; min_ff <= 9'd8;
         hv_ff <= '0; bump_ff <= '0; pool_ff <= '0;
         out_ff <= '0; items_ff <= '0; rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.commit;
         if (cfg_we) begin
            if (cfg_idx == REG_MAX_CLASS) max_ff <= cfg_data;
            else min_ff <= cfg_data;
         end
         if (cmd.commit) begin
            rsp_granted_address <= grant_in;
            rsp_status <= status_in;
            rsp_from_free_list <= reuse_in;
            rsp_pool_bytes_in_use <= pool_in;
            rsp_outside_bytes_in_use <= out_in;
            rsp_live_items <= items_in;
            pool_ff <= pool_in;
            out_ff <= out_in;
            items_ff <= items_in;
            bump_ff <= bump_in;
            if (head_we) begin
               heads_ff[cls_ff] <= head_wd;
               hv_ff[cls_ff] <= 1'b1;
            end
         end
      end
   end
endmodule

>>> dv/testbench.sv
// Self-checking testbench for size_class_free_list_allocator_unit.
// Predicts every word in step with acceptance and checks each rsp_ strobe.
// Depends on scfla_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
   import scfla_pkg::*;

   localparam int POOL  = POOL_BYTES_DEF;
   localparam int GRAN  = GRANULE_BYTES_DEF;
   localparam int NCLS  = NUM_CLASSES_DEF;
   localparam int LINKS = POOL / GRAN;

   typedef struct packed {
      logic [15:0] addr;
      logic [1:0]  st;
      logic        reuse;
      logic [16:0] pool_b;
      logic [31:0] out_b;
      logic [31:0] live;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_ALLOC;
   logic [31:0] req_request_bytes = '0;
   logic [15:0] req_block_address = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = REG_MAX_CLASS;
   logic [8:0]  csr_data = '0;
   logic        rsp_valid;
   logic [15:0] rsp_granted_address;
   logic [1:0]  rsp_status;
   logic        rsp_from_free_list;
   logic [16:0] rsp_pool_bytes_in_use;
   logic [31:0] rsp_outside_bytes_in_use;
   logic [31:0] rsp_live_items;

   // allocator image
   logic [14:0] class_head [NCLS];
   logic [14:0] link_of [LINKS];
   logic [16:0] bump_ptr;
   logic [16:0] pool_used;
   logic [31:0] outside_used;
   logic [31:0] live_count;
   logic [8:0]  max_class_cfg;
   logic [8:0]  min_block_cfg;

   alloc_result_type pending_results[$];
   logic [15:0]   held_addr[$];
   logic [31:0]   held_bytes[$];
   int            fail_count = 0;

   size_class_free_list_allocator_unit dut (.*);

   always #5 clock = ~clock;

   function automatic alloc_result_type predict_alloc(logic op, logic [31:0] bytes,
                                                      logic [15:0] addr);
      alloc_result_type r;
      logic [33:0]   sz;
      logic [33:0]   cls;
      logic          pooled;
      logic [13:0]   gi;
      sz = ({2'b00, bytes} + 34'd3) & ~34'd3;
      if (sz < {25'd0, min_block_cfg}) sz = {25'd0, min_block_cfg};
      cls = sz >> 2;
      pooled = (sz <= {25'd0, max_class_cfg}) && (cls < NCLS);
      r = '0;
      r.st = STATUS_POOL;
      if (!pooled) begin
         r.st = STATUS_OUTSIDE;
         if (op == OP_FREE) begin
            outside_used -= sz[31:0];
            live_count -= 1;
         end else begin
            outside_used += sz[31:0];
            live_count += 1;
         end
      end else if (op == OP_FREE) begin
         gi = addr[15:2];
         live_count -= 1;
         pool_used -= sz[16:0];
         link_of[gi] = class_head[cls];
         class_head[cls] = {1'b0, gi} + 15'd1;
      end else if (class_head[cls] != 0) begin
         gi = 14'(class_head[cls] - 15'd1);
         class_head[cls] = link_of[gi];
         r.addr = {gi, 2'b00};
         r.reuse = 1'b1;
         live_count += 1;
         pool_used += sz[16:0];
      end else if ({17'd0, bump_ptr} + sz <= POOL) begin
         r.addr = bump_ptr[15:0];
         bump_ptr += sz[16:0];
         live_count += 1;
         pool_used += sz[16:0];
      end else begin
         r.st = STATUS_OOM;
      end
      r.pool_b = pool_used;
      r.out_b = outside_used;
      r.live = live_count;
      if (op == OP_ALLOC && r.st == STATUS_POOL) begin
         held_addr.push_back(r.addr);
         held_bytes.push_back(bytes);
      end
      return r;
   endfunction

   task automatic send_word(logic op, logic [31:0] bytes, logic [15:0] addr);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_request_bytes <= bytes;
      req_block_address <= addr;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_alloc(op, bytes, addr));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [8:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_MAX_CLASS) max_class_cfg = val;
      else min_block_cfg = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic free_held(int i);
      logic [15:0] a;
      logic [31:0] b;
      a = held_addr[i];
      b = held_bytes[i];
      held_addr.delete(i);
      held_bytes.delete(i);
      send_word(OP_FREE, b, a | 16'($urandom_range(0, 3)));
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type w;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected word: expected none actual addr %0h", $time,
                     rsp_granted_address);
            fail_count++;
         end else begin
            w = pending_results.pop_front();
            check_field("granted_address", 32'(w.addr), 32'(rsp_granted_address));
            check_field("status", 32'(w.st), 32'(rsp_status));
            check_field("from_free_list", 32'(w.reuse), 32'(rsp_from_free_list));
            check_field("pool_bytes_in_use", 32'(w.pool_b), 32'(rsp_pool_bytes_in_use));
            check_field("outside_bytes_in_use", w.out_b, rsp_outside_bytes_in_use);
            check_field("live_items", w.live, rsp_live_items);
         end
      end
   end

   task automatic test_directed;
      send_word(OP_ALLOC, 32'd0, 16'hFFFF);
      send_word(OP_ALLOC, 32'd1, 16'd0);
      send_word(OP_ALLOC, 32'd256, 16'd0);
      send_word(OP_ALLOC, 32'd257, 16'd0);
      send_word(OP_ALLOC, 32'hFFFF_FFFF, 16'd0);
      send_word(OP_FREE, 32'hFFFF_FFFD, 16'd0);
      send_word(OP_FREE, 32'd5, 16'd11);
      send_word(OP_ALLOC, 32'd6, 16'd0);
      send_word(OP_ALLOC, 32'd8, 16'd0);
      send_word(OP_FREE, 32'd200, 16'hFFFF);
      send_word(OP_ALLOC, 32'd197, 16'd0);
      send_word(OP_FREE, 32'd64, 16'h1234);
      send_word(OP_FREE, 32'd64, 16'h4000);
      send_word(OP_ALLOC, 32'd61, 16'd0);
      send_word(OP_ALLOC, 32'd64, 16'd0);
   endtask

   task automatic test_registers;
      write_csr(REG_MIN_BLOCK, 9'd0);
      send_word(OP_ALLOC, 32'd0, 16'd0);
      send_word(OP_FREE, 32'd0, 16'd40);
      send_word(OP_ALLOC, 32'd0, 16'd0);
      write_csr(REG_MAX_CLASS, 9'd511);
      send_word(OP_ALLOC, 32'd260, 16'd0);
      send_word(OP_ALLOC, 32'd508, 16'd0);
      send_word(OP_ALLOC, 32'd511, 16'd0);
      write_csr(REG_MAX_CLASS, 9'd0);
      send_word(OP_ALLOC, 32'd0, 16'd0);
      send_word(OP_ALLOC, 32'd4, 16'd0);
      write_csr(REG_MAX_CLASS, 9'd4);
      send_word(OP_ALLOC, 32'd3, 16'd0);
      write_csr(REG_MIN_BLOCK, 9'd511);
      send_word(OP_ALLOC, 32'd1, 16'd0);
      send_word(OP_FREE, 32'd1, 16'd0);
      write_csr(REG_MAX_CLASS, 9'd256);
      write_csr(REG_MIN_BLOCK, 9'd256);
      send_word(OP_ALLOC, 32'd1, 16'd0);
   endtask

   task automatic random_phase(logic [8:0] max_b, logic [8:0] min_b, int count);
      int sel;
      write_csr(REG_MAX_CLASS, max_b);
      write_csr(REG_MIN_BLOCK, min_b);
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (n % 97 == 50) drain();
         if (n % 40 < 3) repeat ($urandom_range(0, 1)) @(posedge clock);
         if (sel < 45)
            send_word(OP_ALLOC, $urandom_range(0, 48), 16'($urandom));
         else if (sel < 60)
            send_word(OP_ALLOC, $urandom_range(0, int'(max_b) + 16), 16'($urandom));
         else if (sel < 88 && held_addr.size() != 0)
            free_held($urandom_range(0, held_addr.size() - 1));
         else if (sel < 94)
            send_word(OP_ALLOC, $urandom, 16'($urandom));
         else
            send_word(OP_FREE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 300),
                      16'($urandom));
      end
   endtask

   task automatic test_random;
      random_phase(9'd256, 9'd8, 340);
      random_phase(9'd128, 9'd4, 330);
      random_phase(9'd60, 9'd16, 330);
   endtask

   task automatic test_exhaust;
      write_csr(REG_MAX_CLASS, 9'd256);
      write_csr(REG_MIN_BLOCK, 9'd8);
      while (bump_ptr + 17'd256 <= POOL) send_word(OP_ALLOC, 32'd256, 16'd0);
      send_word(OP_ALLOC, 32'd256, 16'd0);
      send_word(OP_ALLOC, 32'd253, 16'd0);
      if (held_addr.size() != 0) free_held(held_addr.size() - 1);
      send_word(OP_ALLOC, 32'd256, 16'd0);
      send_word(OP_ALLOC, 32'd256, 16'd0);
   endtask

   initial begin
      foreach (class_head[i]) class_head[i] = '0;
      bump_ptr = '0;
      pool_used = '0;
      outside_used = '0;
      live_count = '0;
      max_class_cfg = 9'd256;
      min_block_cfg = 9'd8;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_random();
      test_exhaust();
      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end
endmodule
